### hdl/virtq_block_request_engine_assert.svh
// assertion macros shared by the request engine
`ifndef VIRTQ_BLOCK_REQUEST_ENGINE_ASSERT_SVH
`define VIRTQ_BLOCK_REQUEST_ENGINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define VBRE_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VBRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/vbre_pkg.sv
package vbre_pkg;

    // queue geometry
    localparam int QUEUE_SIZE = 8;
    localparam int IDX_W      = $clog2(QUEUE_SIZE);
    localparam int CHAIN_LEN  = 3;
    localparam int CNT_W      = $clog2(CHAIN_LEN + 1);

    // field widths
    localparam int ADDR_W     = 64;
    localparam int LEN_W      = 17;
    localparam int BN_W       = 32;
    localparam int STRIDE_W   = 7;
    localparam int SPB_W      = 7;
    localparam int STATUS_W   = 8;
    localparam int AVAIL_W    = 16;
    localparam int FLAG_W     = 2;
    localparam int SECTOR_W   = 64;
    localparam int PROD_W     = BN_W + SPB_W;
    localparam int OFF_W      = STRIDE_W + IDX_W;
    localparam int HDR_SHIFT  = 4;
    localparam int HDR_BYTES  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_BASE       = 3'd0,
        CFG_STATUS_BASE       = 3'd1,
        CFG_STATUS_STRIDE     = 3'd2,
        CFG_SECTORS_PER_BLOCK = 3'd3,
        CFG_DATA_LENGTH       = 3'd4
    } t_cfg_reg;

    localparam logic [STRIDE_W-1:0] RST_STATUS_STRIDE = 7'd16;
    localparam logic [SPB_W-1:0]    RST_SPB           = 7'd8;
    localparam logic [LEN_W-1:0]    RST_DATA_LENGTH   = 17'd4096;

    // item modes
    localparam logic MODE_SUBMIT   = 1'b0;
    localparam logic MODE_COMPLETE = 1'b1;

    // descriptor flags
    localparam logic [FLAG_W-1:0] FLAG_NONE  = 2'b00;
    localparam logic [FLAG_W-1:0] FLAG_NEXT  = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_WRITE = 2'b10;

    // result kinds
    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_DESC      = 3'd1,
        KIND_AVAIL     = 3'd2,
        KIND_NO_DESC   = 3'd3,
        KIND_DONE_OK   = 3'd4,
        KIND_DEV_ERR   = 3'd5,
        KIND_CHAIN_ERR = 3'd6
    } t_kind;

    typedef struct packed {
        logic [ADDR_W-1:0]   header_base;
        logic [ADDR_W-1:0]   status_base;
        logic [STRIDE_W-1:0] status_stride;
        logic [SPB_W-1:0]    sectors_per_block;
        logic [LEN_W-1:0]    data_length;
    } t_cfg;

    // one link memory entry
    typedef struct packed {
        logic [FLAG_W-1:0] flags;
        logic [IDX_W-1:0]  next;
    } t_link;

    typedef struct packed {
        logic                               ok;
        logic [CHAIN_LEN-1:0][IDX_W-1:0]    idx;
    } t_alloc;

    typedef struct packed {
        t_kind               kind;
        logic [IDX_W-1:0]    desc_index;
        logic [ADDR_W-1:0]   address;
        logic [LEN_W-1:0]    length;
        logic [FLAG_W-1:0]   flags;
        logic [IDX_W-1:0]    next_index;
        logic                req_type;
        logic [SECTOR_W-1:0] sector;
        logic [IDX_W-1:0]    ring_slot;
        logic [AVAIL_W-1:0]  avail_count;
        logic                last;
    } t_rsp;

    // pick the three lowest free descriptors
    function automatic t_alloc find_free(input logic [QUEUE_SIZE-1:0] free);
        t_alloc           a;
        logic [CNT_W-1:0] cnt;
        a   = '0;
        cnt = '0;
        for (int i = 0; i < QUEUE_SIZE; i++) begin
            if (free[i] && (cnt < CNT_W'(CHAIN_LEN))) begin
                a.idx[cnt] = IDX_W'(i);
                cnt        = cnt + CNT_W'(1);
            end
        end
        a.ok = (cnt == CNT_W'(CHAIN_LEN));
        return a;
    endfunction

endpackage

### hdl/vbre_if.sv
// request channel
interface vbre_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic                          is_write;
    logic [vbre_pkg::BN_W-1:0]     block_number;
    logic [vbre_pkg::ADDR_W-1:0]   page_address;
    logic [vbre_pkg::IDX_W-1:0]    used_id;
    logic [vbre_pkg::STATUS_W-1:0] device_status;

    modport source (
        output valid, mode, is_write, block_number, page_address, used_id, device_status,
        input  ready
    );
    modport sink (
        input  valid, mode, is_write, block_number, page_address, used_id, device_status,
        output ready
    );
endinterface

// result channel
interface vbre_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    kind;
    logic [vbre_pkg::IDX_W-1:0]    desc_index;
    logic [vbre_pkg::ADDR_W-1:0]   address;
    logic [vbre_pkg::LEN_W-1:0]    length;
    logic [vbre_pkg::FLAG_W-1:0]   flags;
    logic [vbre_pkg::IDX_W-1:0]    next_index;
    logic                          req_type;
    logic [vbre_pkg::SECTOR_W-1:0] sector;
    logic [vbre_pkg::IDX_W-1:0]    ring_slot;
    logic [vbre_pkg::AVAIL_W-1:0]  avail_count;
    logic                          last;

    modport source (
        output valid, kind, desc_index, address, length, flags, next_index, req_type,
               sector, ring_slot, avail_count, last,
        input  ready
    );
    modport sink (
        input  valid, kind, desc_index, address, length, flags, next_index, req_type,
               sector, ring_slot, avail_count, last,
        output ready
    );
endinterface

### hdl/vbre_cfg.sv
module vbre_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vbre_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vbre_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output vbre_pkg::t_cfg                    o_cfg
);

    vbre_pkg::t_cfg r_cfg;

    // register writes, masked to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_base       <= '0;
            r_cfg.status_base       <= '0;
            r_cfg.status_stride     <= vbre_pkg::RST_STATUS_STRIDE;
            r_cfg.sectors_per_block <= vbre_pkg::RST_SPB;
            r_cfg.data_length       <= vbre_pkg::RST_DATA_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vbre_pkg::CFG_HEADER_BASE: begin
                    r_cfg.header_base <= i_cfg_data[vbre_pkg::ADDR_W-1:0];
                end
                vbre_pkg::CFG_STATUS_BASE: begin
                    r_cfg.status_base <= i_cfg_data[vbre_pkg::ADDR_W-1:0];
                end
                vbre_pkg::CFG_STATUS_STRIDE: begin
                    r_cfg.status_stride <= i_cfg_data[vbre_pkg::STRIDE_W-1:0];
                end
                vbre_pkg::CFG_SECTORS_PER_BLOCK: begin
                    r_cfg.sectors_per_block <= i_cfg_data[vbre_pkg::SPB_W-1:0];
                end
                vbre_pkg::CFG_DATA_LENGTH: begin
                    r_cfg.data_length <= i_cfg_data[vbre_pkg::LEN_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/vbre_link_mem.sv
module vbre_link_mem (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [vbre_pkg::IDX_W-1:0]     i_waddr,
    input  vbre_pkg::t_link                i_wdata,
    input  logic [vbre_pkg::IDX_W-1:0]     i_raddr,
    output vbre_pkg::t_link                o_rdata
);

    vbre_pkg::t_link mem [vbre_pkg::QUEUE_SIZE];
    vbre_pkg::t_link r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/virtq_block_request_engine.sv
// Block request engine for a split virtqueue, driver side. Descriptor flags and next links
// live in a small link memory with one write port and one registered read port; the free
// map and the avail index are registers. One item is worked at a time, but a new item is
// taken while the last result still waits in the output register. A submit steps through
// accept, a step for the sector product, the header address and the status offset, then
// five result beats, one a cycle unless the output stalls, during which the three chain
// entries are written to the link memory. When fewer than three descriptors are free a
// submit is accepted and gives one no-descriptor result. A completion walks the chain:
// each descriptor that passes the free and repeat check takes a link memory read, then a
// link check; a descriptor that fails that check ends the walk. The walk follows accept
// and ends in one result beat. Output back-pressure can stall result beats. No clearing
// pass is needed after reset.
`include "virtq_block_request_engine_assert.svh"

module virtq_block_request_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vbre_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vbre_pkg::CFG_DATA_W-1:0] i_cfg_data,
    vbre_req_if.sink                        i_req,
    vbre_rsp_if.source                      o_rsp
);

    localparam logic [2:0] STEP_HEADER = 3'd0;
    localparam logic [2:0] STEP_HDESC  = 3'd1;
    localparam logic [2:0] STEP_DDESC  = 3'd2;
    localparam logic [2:0] STEP_SDESC  = 3'd3;
    localparam logic [2:0] STEP_AVAIL  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_EMIT,
        S_FULL,
        S_WALK,
        S_CHK,
        S_END
    } t_state;

    t_state                               r_state;
    logic [2:0]                           r_step;
    logic [vbre_pkg::QUEUE_SIZE-1:0]      r_free;
    logic [vbre_pkg::AVAIL_W-1:0]         r_avail;
    vbre_pkg::t_alloc                     r_alloc;
    logic                                 r_is_write;
    logic [vbre_pkg::BN_W-1:0]            r_block;
    logic [vbre_pkg::ADDR_W-1:0]          r_page;
    logic [vbre_pkg::IDX_W-1:0]           r_head;
    logic [vbre_pkg::STATUS_W-1:0]        r_status;
    logic [vbre_pkg::PROD_W-1:0]          r_sector;
    logic [vbre_pkg::ADDR_W-1:0]          r_hdr_addr;
    logic [vbre_pkg::OFF_W-1:0]           r_stat_off;
    logic [vbre_pkg::IDX_W-1:0]           r_cur;
    logic [vbre_pkg::QUEUE_SIZE-1:0]      r_visit;
    logic [vbre_pkg::CNT_W-1:0]           r_n;
    logic                                 r_good;
    logic                                 r_out_valid;
    vbre_pkg::t_rsp                       r_out;

    vbre_pkg::t_cfg                       w_cfg;
    vbre_pkg::t_alloc                     w_alloc;
    vbre_pkg::t_link                      w_link;
    vbre_pkg::t_link                      w_wdata;
    vbre_pkg::t_rsp                       n_beat;
    logic [vbre_pkg::CNT_W-1:0]           n_count;
    logic                                 w_out_free;
    logic                                 w_emit;
    logic                                 w_load;
    logic                                 w_mem_we;
    logic                                 w_walk_bad;

    // configuration registers
    vbre_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // flags and next link of every descriptor
    vbre_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (n_beat.desc_index),
        .i_wdata (w_wdata),
        .i_raddr (r_cur),
        .o_rdata (w_link)
    );

    // lowest three free descriptors
    assign w_alloc = vbre_pkg::find_free(r_free);

    // output register handshake
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_emit     = (r_state == S_EMIT) || (r_state == S_FULL) || (r_state == S_END);
    assign w_load     = w_emit && w_out_free;

    // chain entries go to the link memory as their descriptor beats are loaded
    assign w_mem_we = w_load && (r_state == S_EMIT) &&
                      ((r_step == STEP_HDESC) || (r_step == STEP_DDESC) ||
                       (r_step == STEP_SDESC));
    assign w_wdata.flags = n_beat.flags;
    assign w_wdata.next  = n_beat.next_index;

    // walk checks: out of range, already free, or seen before in this chain
    assign w_walk_bad = r_free[r_cur] || r_visit[r_cur] ||
                        ({1'b0, r_cur} >= (vbre_pkg::IDX_W + 1)'(vbre_pkg::QUEUE_SIZE));
    assign n_count    = r_n + vbre_pkg::CNT_W'(1);

    // next result beat
    always_comb begin
        n_beat = '0;
        unique case (r_state)
            S_EMIT: begin
                unique case (r_step)
                    STEP_HEADER: begin
                        n_beat.kind       = vbre_pkg::KIND_HEADER;
                        n_beat.desc_index = r_alloc.idx[0];
                        n_beat.address    = r_hdr_addr;
                        n_beat.req_type   = r_is_write;
                        n_beat.sector     = vbre_pkg::SECTOR_W'(r_sector);
                    end
                    STEP_HDESC: begin
                        n_beat.kind       = vbre_pkg::KIND_DESC;
                        n_beat.desc_index = r_alloc.idx[0];
                        n_beat.address    = r_hdr_addr;
                        n_beat.length     = vbre_pkg::LEN_W'(vbre_pkg::HDR_BYTES);
                        n_beat.flags      = vbre_pkg::FLAG_NEXT;
                        n_beat.next_index = r_alloc.idx[1];
                    end
                    STEP_DDESC: begin
                        n_beat.kind       = vbre_pkg::KIND_DESC;
                        n_beat.desc_index = r_alloc.idx[1];
                        n_beat.address    = r_page;
                        n_beat.length     = w_cfg.data_length;
                        n_beat.flags      = vbre_pkg::FLAG_NEXT |
                                            (r_is_write ? vbre_pkg::FLAG_NONE
                                                        : vbre_pkg::FLAG_WRITE);
                        n_beat.next_index = r_alloc.idx[2];
                    end
                    STEP_SDESC: begin
                        n_beat.kind       = vbre_pkg::KIND_DESC;
                        n_beat.desc_index = r_alloc.idx[2];
                        n_beat.address    = w_cfg.status_base +
                                            vbre_pkg::ADDR_W'(r_stat_off);
                        n_beat.length     = vbre_pkg::LEN_W'(1);
                        n_beat.flags      = vbre_pkg::FLAG_WRITE;
                    end
                    default: begin
                        n_beat.kind        = vbre_pkg::KIND_AVAIL;
                        n_beat.desc_index  = r_alloc.idx[0];
                        n_beat.ring_slot   = r_avail[vbre_pkg::IDX_W-1:0];
                        n_beat.avail_count = r_avail + vbre_pkg::AVAIL_W'(1);
                        n_beat.last        = 1'b1;
                    end
                endcase
            end
            S_FULL: begin
                n_beat.kind = vbre_pkg::KIND_NO_DESC;
                n_beat.last = 1'b1;
            end
            S_END: begin
                n_beat.desc_index = r_head;
                n_beat.last       = 1'b1;
                if (!r_good) begin
                    n_beat.kind = vbre_pkg::KIND_CHAIN_ERR;
                end else if (r_status == '0) begin
                    n_beat.kind = vbre_pkg::KIND_DONE_OK;
                end else begin
                    n_beat.kind = vbre_pkg::KIND_DEV_ERR;
                end
            end
            default: begin
                n_beat = '0;
            end
        endcase
    end

    // sequencer, free map, avail index and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_HEADER;
            r_free      <= '1;
            r_avail     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out       <= n_beat;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_is_write <= i_req.is_write;
                        r_block    <= i_req.block_number;
                        r_page     <= i_req.page_address;
                        r_head     <= i_req.used_id;
                        r_status   <= i_req.device_status;
                        r_cur      <= i_req.used_id;
                        r_visit    <= '0;
                        r_n        <= '0;
                        r_good     <= 1'b1;
                        r_alloc    <= w_alloc;
                        if (i_req.mode == vbre_pkg::MODE_COMPLETE) begin
                            r_state <= S_WALK;
                        end else if (w_alloc.ok) begin
                            r_free[w_alloc.idx[0]] <= 1'b0;
                            r_free[w_alloc.idx[1]] <= 1'b0;
                            r_free[w_alloc.idx[2]] <= 1'b0;
                            r_state                <= S_CALC;
                        end else begin
                            r_state <= S_FULL;
                        end
                    end
                end
                S_CALC: begin
                    r_sector   <= vbre_pkg::PROD_W'(r_block) *
                                  vbre_pkg::PROD_W'(w_cfg.sectors_per_block);
                    r_hdr_addr <= w_cfg.header_base +
                                  (vbre_pkg::ADDR_W'(r_alloc.idx[0]) << vbre_pkg::HDR_SHIFT);
                    r_stat_off <= vbre_pkg::OFF_W'(w_cfg.status_stride) *
                                  vbre_pkg::OFF_W'(r_alloc.idx[0]);
                    r_step     <= STEP_HEADER;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_load) begin
                        if (r_step == STEP_AVAIL) begin
                            r_avail <= r_avail + vbre_pkg::AVAIL_W'(1);
                            r_state <= S_IDLE;
                        end else begin
                            r_step <= r_step + 3'd1;
                        end
                    end
                end
                S_FULL: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                S_WALK: begin
                    if (w_walk_bad) begin
                        r_good  <= 1'b0;
                        r_state <= S_END;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_visit[r_cur] <= 1'b1;
                    r_n            <= n_count;
                    if ((w_link.flags & vbre_pkg::FLAG_NEXT) == vbre_pkg::FLAG_NONE) begin
                        r_state <= S_END;
                    end else if (n_count >= vbre_pkg::CNT_W'(vbre_pkg::CHAIN_LEN)) begin
                        r_good  <= 1'b0;
                        r_state <= S_END;
                    end else begin
                        r_cur   <= w_link.next;
                        r_state <= S_WALK;
                    end
                end
                S_END: begin
                    if (w_load) begin
                        if (r_good) begin
                            r_free <= r_free | r_visit;
                        end
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // port wiring
    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.kind        = r_out.kind;
    assign o_rsp.desc_index  = r_out.desc_index;
    assign o_rsp.address     = r_out.address;
    assign o_rsp.length      = r_out.length;
    assign o_rsp.flags       = r_out.flags;
    assign o_rsp.next_index  = r_out.next_index;
    assign o_rsp.req_type    = r_out.req_type;
    assign o_rsp.sector      = r_out.sector;
    assign o_rsp.ring_slot   = r_out.ring_slot;
    assign o_rsp.avail_count = r_out.avail_count;
    assign o_rsp.last        = r_out.last;

    // claimed descriptors stay out of the free map while their beats go out
    `VBRE_ASSERT_HOLD(a_claim_held, i_clk, i_rst_n, (r_state == S_CALC) || (r_state == S_EMIT), !r_free[r_alloc.idx[0]] && !r_free[r_alloc.idx[1]] && !r_free[r_alloc.idx[2]], "claimed descriptor marked free")

    // a pending avail beat always shows the current avail index
    `VBRE_ASSERT_HOLD(a_avail_match, i_clk, i_rst_n, r_out_valid && (r_out.kind == vbre_pkg::KIND_AVAIL), r_out.avail_count == r_avail, "avail beat out of step with avail index")

    // a good completion returns descriptors to the free map
    `VBRE_ASSERT_NEXT(a_free_grows, i_clk, i_rst_n, (r_state == S_END) && w_load && r_good, $countones(r_free) > $past($countones(r_free)), "completed chain freed nothing")

endmodule
